### src/lsps_pkg.sv
package lsps_pkg;

  localparam int unsigned SENSOR_BITS_DEF = 8;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned KP_W       = 10;
  localparam int unsigned KD_W       = 8;
  localparam int unsigned SPEED_W    = 7;
  localparam int unsigned THR_W      = 8;
  localparam int unsigned MARKER_W   = 8;
  localparam int unsigned ERR_W      = 12;
  localparam int unsigned DRIVE_W    = 8;
  localparam int unsigned STEER_W    = 8;

  localparam int unsigned DIFF_W     = 13;
  localparam int unsigned ACC_W      = 23;
  localparam int unsigned PID_W      = 12;
  localparam int unsigned PREV_ITERS = 15;
  localparam int unsigned PID_ITERS  = 22;
  localparam int unsigned PREVQ_W    = 10;

  localparam int unsigned CENTRE_OFFSET = 2500;
  localparam int unsigned HOLD_PREV     = 30000;
  localparam int unsigned SCALE         = 1000;
  localparam int unsigned PREV_DIV      = 100;
  localparam int signed   ERR_LIMIT     = 1500;

  localparam logic [KP_W-1:0]    KP_RST    = KP_W'(75);
  localparam logic [KD_W-1:0]    KD_RST    = KD_W'(4);
  localparam logic [SPEED_W-1:0] FAST_RST  = SPEED_W'(37);
  localparam logic [SPEED_W-1:0] SLOW_RST  = SPEED_W'(18);
  localparam logic [SPEED_W-1:0] MARK_RST  = SPEED_W'(12);
  localparam logic [SPEED_W-1:0] HOLD_RST  = SPEED_W'(19);
  localparam logic [THR_W-1:0]   THR_RST   = THR_W'(180);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP         = 3'd0,
    REG_KD         = 3'd1,
    REG_FAST_SPEED = 3'd2,
    REG_SLOW_SPEED = 3'd3,
    REG_MARK_SPEED = 3'd4,
    REG_HOLD_SPEED = 3'd5,
    REG_MARK_THR   = 3'd6
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CENT_GO,
    ST_CENT_WAIT,
    ST_PREV_GO,
    ST_PREV_WAIT,
    ST_MUL_P,
    ST_MUL_D,
    ST_PID_GO,
    ST_PID_WAIT,
    ST_FIN
  } state_e;

endpackage

### src/lsps_if.sv
interface lsps_item_if #(
  parameter int unsigned SENSOR_BITS = 8
);
  import lsps_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [SENSOR_BITS-1:0] sensor_one;
  logic [SENSOR_BITS-1:0] sensor_two;
  logic [SENSOR_BITS-1:0] sensor_three;
  logic [SENSOR_BITS-1:0] sensor_four;
  logic [MARKER_W-1:0]    left_marker_sample;
  logic                   hold_mode;

  modport source (
    output valid, sensor_one, sensor_two, sensor_three, sensor_four,
           left_marker_sample, hold_mode,
    input  ready
  );
  modport sink (
    input  valid, sensor_one, sensor_two, sensor_three, sensor_four,
           left_marker_sample, hold_mode,
    output ready
  );
endinterface

interface lsps_result_if;
  import lsps_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [DRIVE_W-1:0]        left_drive;
  logic [DRIVE_W-1:0]        right_drive;
  logic signed [STEER_W-1:0] steer_value;
  logic signed [ERR_W-1:0]   line_error;
  logic                      straight_flag;
  logic                      no_line_flag;

  modport source (
    output valid, left_drive, right_drive, steer_value, line_error,
           straight_flag, no_line_flag,
    input  ready
  );
  modport sink (
    input  valid, left_drive, right_drive, steer_value, line_error,
           straight_flag, no_line_flag,
    output ready
  );
endinterface

interface lsps_cfg_if;
  import lsps_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

### src/lsps_div.sv
module lsps_div #(
  parameter int unsigned DW = 22,
  parameter int unsigned RW = 10,
  parameter int unsigned CW = $clog2(DW + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [RW-1:0] divisor_i,
  input  logic [CW-1:0] iters_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  logic [RW-1:0] rem_q;
  logic [DW-1:0] quo_q;
  logic [RW-1:0] dvs_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  logic [RW:0] shifted;
  logic [RW:0] trial;
  logic        fits;

  assign shifted = {rem_q, quo_q[DW-1]};
  assign fits    = shifted >= {1'b0, dvs_q};
  assign trial   = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= iters_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial[RW-1:0] : shifted[RW-1:0];
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### src/line_sensor_pd_steering_unit.sv
// One item is worked at a time: the input is ready only in the idle state, and the
// shared restoring divider runs in turn for the centroid (skipped when the sensor
// sum is zero), previous/100 and steer/1000.
// A new item is taken while an earlier result still waits on the output.
// Reset: async active low; gains, speeds and marker threshold take defaults, previous error 0.
module line_sensor_pd_steering_unit #(
  parameter int unsigned SENSOR_BITS = lsps_pkg::SENSOR_BITS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  lsps_item_if.sink     item_i,
  lsps_result_if.source result_o,
  lsps_cfg_if.sink      cfg_i
);
  import lsps_pkg::*;

  localparam int unsigned SB     = SENSOR_BITS;
  localparam int unsigned SUM_W  = SB + 2;
  localparam int unsigned WSUM_W = SB + 4;
  localparam int unsigned DW     = SB + 14;
  localparam int unsigned RW     = SB + 2;
  localparam int unsigned CW     = $clog2(DW + 1);

  // configuration
  logic [KP_W-1:0]    kp_q;
  logic [KD_W-1:0]    kd_q;
  logic [SPEED_W-1:0] fast_q, slow_q, mark_q, hold_spd_q;
  logic [THR_W-1:0]   thr_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q       <= KP_RST;
      kd_q       <= KD_RST;
      fast_q     <= FAST_RST;
      slow_q     <= SLOW_RST;
      mark_q     <= MARK_RST;
      hold_spd_q <= HOLD_RST;
      thr_q      <= THR_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_KP:         kp_q       <= cfg_i.data[KP_W-1:0];
        REG_KD:         kd_q       <= cfg_i.data[KD_W-1:0];
        REG_FAST_SPEED: fast_q     <= cfg_i.data[SPEED_W-1:0];
        REG_SLOW_SPEED: slow_q     <= cfg_i.data[SPEED_W-1:0];
        REG_MARK_SPEED: mark_q     <= cfg_i.data[SPEED_W-1:0];
        REG_HOLD_SPEED: hold_spd_q <= cfg_i.data[SPEED_W-1:0];
        REG_MARK_THR:   thr_q      <= cfg_i.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  state_e state_q, state_d;

  logic [SB-1:0]       s2_q, s3_q;
  logic [MARKER_W-1:0] marker_q;
  logic                hold_q;
  logic [SUM_W-1:0]    sum_q;
  logic [WSUM_W-1:0]   wsum_q;
  logic signed [ERR_W-1:0]  err_q;
  logic signed [ERR_W-1:0]  prev_err_q;
  logic                     no_line_q;
  logic                     prev_neg_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [PID_W-1:0]  pid_q;

  logic                res_valid_q;
  logic [DRIVE_W-1:0]  res_left_q, res_right_q;
  logic signed [STEER_W-1:0] res_steer_q;
  logic signed [ERR_W-1:0]   res_err_q;
  logic                res_straight_q, res_noline_q;

  logic          item_take;
  logic          res_free;
  logic          div_start;
  logic [DW-1:0] div_dividend;
  logic [RW-1:0] div_divisor;
  logic [CW-1:0] div_iters;
  logic          div_busy, div_done;
  logic [DW-1:0] div_quot;

  assign item_take = item_i.valid && item_i.ready;
  assign res_free  = !res_valid_q || result_o.ready;

  // input sums
  logic [SUM_W-1:0]  sum_in;
  logic [WSUM_W-1:0] wsum_in;
  logic [WSUM_W-1:0] e1, e2, e3, e4;

  assign e1      = WSUM_W'(item_i.sensor_one);
  assign e2      = WSUM_W'(item_i.sensor_two);
  assign e3      = WSUM_W'(item_i.sensor_three);
  assign e4      = WSUM_W'(item_i.sensor_four);
  assign wsum_in = e1 + (e2 << 1) + (e3 << 1) + e3 + (e4 << 2);
  assign sum_in  = SUM_W'(e1 + e2 + e3 + e4);

  // wsum * 1000 = wsum * (1024 - 16 - 8)
  logic [DW-1:0] wsum_ext, scaled;
  assign wsum_ext = DW'(wsum_q);
  assign scaled   = (wsum_ext << 10) - (wsum_ext << 4) - (wsum_ext << 3);

  // previous error / 100 operand
  logic signed [15:0] prev_src;
  logic [PREV_ITERS-1:0] prev_abs;
  assign prev_src = hold_q ? $signed(16'(HOLD_PREV)) : 16'(prev_err_q);
  assign prev_abs = prev_src[15] ? PREV_ITERS'(-prev_src) : PREV_ITERS'(prev_src);

  logic [PID_ITERS-1:0] acc_abs;
  assign acc_abs = acc_q[ACC_W-1] ? PID_ITERS'(-acc_q) : PID_ITERS'(acc_q);

  // shared multiplier
  logic signed [ACC_W-1:0] mul_a, mul_b, prod;
  assign mul_a = (state_q == ST_MUL_P) ? ACC_W'(err_q) : ACC_W'(diff_q);
  assign mul_b = (state_q == ST_MUL_P) ? $signed(ACC_W'(kp_q)) : $signed(ACC_W'(kd_q));
  assign prod  = mul_a * mul_b;

  // division results
  logic signed [ERR_W:0]     cent_err;
  logic signed [PREVQ_W-1:0] prevq_mag, prevq;
  logic signed [PID_W-1:0]   pid_mag;
  assign cent_err  = $signed({1'b0, div_quot[ERR_W-1:0]}) - (ERR_W+1)'(CENTRE_OFFSET);
  assign prevq_mag = $signed({1'b0, div_quot[PREVQ_W-2:0]});
  assign prevq     = prev_neg_q ? -prevq_mag : prevq_mag;
  assign pid_mag   = $signed({1'b0, div_quot[PID_W-2:0]});

  // speed selection and clamp
  logic                    straight;
  logic [SPEED_W-1:0]      speed;
  logic signed [PID_W-1:0] speed_s, steer;
  logic signed [DRIVE_W:0] left_w, right_w;

  assign straight = (s2_q != '0) && ({1'b0, s3_q, 1'b0} < {2'b00, s2_q});

  always_comb begin
    speed = straight ? fast_q : slow_q;
    if (marker_q > thr_q) begin
      speed = mark_q;
    end
    if (hold_q) begin
      speed = hold_spd_q;
    end
    speed_s = $signed(PID_W'(speed));
    steer   = pid_q;
    if (pid_q > speed_s) begin
      steer = speed_s;
    end else if (pid_q < -speed_s) begin
      steer = -speed_s;
    end
    left_w  = $signed((DRIVE_W+1)'(speed)) - (DRIVE_W+1)'(steer);
    right_w = $signed((DRIVE_W+1)'(speed)) + (DRIVE_W+1)'(steer);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (item_take) state_d = ST_CENT_GO;
      ST_CENT_GO:   state_d = (sum_q == '0) ? ST_PREV_GO : ST_CENT_WAIT;
      ST_CENT_WAIT: if (div_done) state_d = ST_PREV_GO;
      ST_PREV_GO:   state_d = ST_PREV_WAIT;
      ST_PREV_WAIT: if (div_done) state_d = ST_MUL_P;
      ST_MUL_P:     state_d = ST_MUL_D;
      ST_MUL_D:     state_d = ST_PID_GO;
      ST_PID_GO:    state_d = ST_PID_WAIT;
      ST_PID_WAIT:  if (div_done) state_d = ST_FIN;
      ST_FIN:       if (res_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    div_start    = 1'b0;
    div_dividend = scaled;
    div_divisor  = sum_q;
    div_iters    = CW'(DW);
    case (state_q)
      ST_CENT_GO: begin
        div_start = (sum_q != '0);
      end
      ST_PREV_GO: begin
        div_start    = 1'b1;
        div_dividend = DW'(prev_abs) << (DW - PREV_ITERS);
        div_divisor  = RW'(PREV_DIV);
        div_iters    = CW'(PREV_ITERS);
      end
      ST_PID_GO: begin
        div_start    = 1'b1;
        div_dividend = DW'(acc_abs) << (DW - PID_ITERS);
        div_divisor  = RW'(SCALE);
        div_iters    = CW'(PID_ITERS);
      end
      default: ;
    endcase
  end

  assign item_i.ready = (state_q == ST_IDLE);

  lsps_div #(
    .DW (DW),
    .RW (RW),
    .CW (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .iters_i    (div_iters),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_err_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_FIN && res_free) begin
        res_valid_q <= 1'b1;
        if (!hold_q) begin
          prev_err_q <= err_q;
        end
      end else if (result_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (item_take) begin
          s2_q     <= item_i.sensor_two;
          s3_q     <= item_i.sensor_three;
          marker_q <= item_i.left_marker_sample;
          hold_q   <= item_i.hold_mode;
          sum_q    <= sum_in;
          wsum_q   <= wsum_in;
        end
      end
      ST_CENT_GO: begin
        err_q     <= '0;
        no_line_q <= (sum_q == '0);
      end
      ST_CENT_WAIT: begin
        if (div_done) begin
          err_q <= ERR_W'(cent_err);
        end
      end
      ST_PREV_GO: begin
        prev_neg_q <= prev_src[15];
      end
      ST_PREV_WAIT: begin
        if (div_done) begin
          diff_q <= DIFF_W'(err_q) - DIFF_W'(prevq);
        end
      end
      ST_MUL_P: begin
        acc_q <= prod;
      end
      ST_MUL_D: begin
        acc_q <= acc_q + prod;
      end
      ST_PID_WAIT: begin
        if (div_done) begin
          pid_q <= acc_q[ACC_W-1] ? -pid_mag : pid_mag;
        end
      end
      ST_FIN: begin
        if (res_free) begin
          res_left_q     <= left_w[DRIVE_W-1:0];
          res_right_q    <= right_w[DRIVE_W-1:0];
          res_steer_q    <= steer[STEER_W-1:0];
          res_err_q      <= err_q;
          res_straight_q <= straight;
          res_noline_q   <= no_line_q;
        end
      end
      default: ;
    endcase
  end

  assign result_o.valid         = res_valid_q;
  assign result_o.left_drive    = res_left_q;
  assign result_o.right_drive   = res_right_q;
  assign result_o.steer_value   = res_steer_q;
  assign result_o.line_error    = res_err_q;
  assign result_o.straight_flag = res_straight_q;
  assign result_o.no_line_flag  = res_noline_q;

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take |=> !item_i.ready)
    else $error("input taken again while an item is in work");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_err_q >= -12'sd1500 && res_err_q <= 12'sd1500))
    else $error("line error out of range");

  a_no_line_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_noline_q |-> res_err_q == '0)
    else $error("line error nonzero without a line");

endmodule
